/* hw/rtl/flpc_pkg.sv */
// shared types, constants and helpers for the float level pump controller
package flpc_pkg;

  localparam logic [1:0] LEVEL_UNKNOWN = 2'd0;
  localparam logic [1:0] LEVEL_FULL    = 2'd1;
  localparam logic [1:0] LEVEL_EMPTY   = 2'd2;

  localparam logic [2:0] REG_STOP_COUNT  = 3'd0;
  localparam logic [2:0] REG_START_COUNT = 3'd1;
  localparam logic [2:0] REG_RUN_PCT     = 3'd2;
  localparam logic [2:0] REG_BOOST_PCT   = 3'd3;
  localparam logic [2:0] REG_BOOST_TICKS = 3'd4;
  localparam logic [2:0] REG_PWM_TOP     = 3'd5;

  localparam logic [7:0]  RST_STOP_COUNT  = 8'd20;
  localparam logic [7:0]  RST_START_COUNT = 8'd60;
  localparam logic [6:0]  RST_RUN_PCT     = 7'd40;
  localparam logic [6:0]  RST_BOOST_PCT   = 7'd60;
  localparam logic [15:0] RST_BOOST_TICKS = 16'd80;
  localparam logic [15:0] RST_PWM_TOP     = 16'd249;

  localparam logic [6:0] PERCENT_MAX = 7'd100;
  localparam logic [7:0] DIVISOR     = 8'd100;
  localparam int         PROD_W      = 23;
  localparam int         QUO_W       = 17;
  localparam int         RECIP_W     = 24;
  localparam int         SCALED_W    = PROD_W + RECIP_W;
  // ceil(2^30 / 100), exact floor divide by 100 for any product below 2^23
  localparam logic [RECIP_W-1:0] RECIP_100   = 24'd10737419;
  localparam int                 RECIP_SHIFT = 30;
  localparam logic [1:0]         CALC_CYCLES = 2'd3;

  typedef struct packed {
    logic [7:0]  stop_count;
    logic [7:0]  start_count;
    logic [6:0]  run_pct;
    logic [6:0]  boost_pct;
    logic [15:0] boost_ticks;
    logic [15:0] pwm_top;
  } cfg_t;

  typedef struct packed {
    logic        seeding;
    logic        boosting;
    logic        pump_on;
    logic [1:0]  level_state;
    logic [15:0] duty;
  } result_t;

  function automatic logic [7:0] count_up(input logic [7:0] c, input logic [7:0] limit);
    logic [7:0] n;
    n = (c != 8'hFF) ? c + 8'd1 : 8'hFF;
    return (n > limit) ? limit : n;
  endfunction

endpackage

/* hw/rtl/float_level_pump_controller.sv */
// an accepted item is held in the input register, its result in the output register
// throughput: one item per cycle unless stalled; an item enters while a result waits
// compare values come from a 3-stage multiply and reciprocal divide pipeline;
// after reset and after every config write no item is taken until the busy count is zero
// reset: synchronous active-low rst_n clears control state and loads register defaults
module float_level_pump_controller
  import flpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] switch_wet, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] duty, [17:16] level_state, [18] pump_on,
                                  // [19] boosting, [20] seeding, [23:21] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg_r;
  logic        in_valid_r;
  logic        in_water_r;
  logic        out_valid_r;
  result_t     out_res_r;

  logic        cfg_wr;
  logic        calc_done;
  logic        calc_ready;
  logic        advance;
  logic [15:0] run_cmp;
  logic [15:0] boost_cmp;
  result_t     res;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid;
  assign calc_ready = calc_done && !cfg_wr;
  assign advance    = in_valid_r && calc_ready && (!out_valid_r || out_tready);
  assign in_tready  = calc_ready && (!in_valid_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_count  <= RST_STOP_COUNT;
      cfg_r.start_count <= RST_START_COUNT;
      cfg_r.run_pct     <= RST_RUN_PCT;
      cfg_r.boost_pct   <= RST_BOOST_PCT;
      cfg_r.boost_ticks <= RST_BOOST_TICKS;
      cfg_r.pwm_top     <= RST_PWM_TOP;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_STOP_COUNT:  cfg_r.stop_count  <= cfg_data[7:0];
        REG_START_COUNT: cfg_r.start_count <= cfg_data[7:0];
        REG_RUN_PCT:     cfg_r.run_pct     <= cfg_data[6:0];
        REG_BOOST_PCT:   cfg_r.boost_pct   <= cfg_data[6:0];
        REG_BOOST_TICKS: cfg_r.boost_ticks <= cfg_data;
        REG_PWM_TOP:     cfg_r.pwm_top     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_water_r <= in_tdata[0];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  flpc_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_wr),
    .cfg       (cfg_r),
    .done      (calc_done),
    .run_cmp   (run_cmp),
    .boost_cmp (boost_cmp)
  );

  flpc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .water      (in_water_r),
    .cfg        (cfg_r),
    .seed_load  (cfg_wr && (cfg_index == REG_START_COUNT)),
    .seed_value (cfg_data[7:0]),
    .run_cmp    (run_cmp),
    .boost_cmp  (boost_cmp),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

/* hw/rtl/flpc_calc.sv */
// percent to compare value conversion: multiply, reciprocal divide by 100, minus one, clamp
module flpc_calc
  import flpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  cfg_t        cfg,
  output logic        done,
  output logic [15:0] run_cmp,
  output logic [15:0] boost_cmp
);

  logic [1:0]         busy_r, busy_nxt;
  logic [PROD_W-1:0]  run_prod_r, run_prod_nxt;
  logic [PROD_W-1:0]  boost_prod_r, boost_prod_nxt;
  logic [QUO_W-1:0]   run_quo_r, run_quo_nxt;
  logic [QUO_W-1:0]   boost_quo_r, boost_quo_nxt;
  logic [15:0]        run_cmp_r, run_cmp_nxt;
  logic [15:0]        boost_cmp_r, boost_cmp_nxt;

  logic [6:0]          run_pct_c;
  logic [6:0]          boost_pct_c;
  logic [16:0]         top_inc;
  logic [SCALED_W-1:0] run_scaled;
  logic [SCALED_W-1:0] boost_scaled;
  logic [QUO_W-1:0]    run_dec;
  logic [QUO_W-1:0]    boost_dec;

  always_comb begin
    run_pct_c   = (cfg.run_pct > PERCENT_MAX) ? PERCENT_MAX : cfg.run_pct;
    boost_pct_c = (cfg.boost_pct > PERCENT_MAX) ? PERCENT_MAX : cfg.boost_pct;
    top_inc     = {1'b0, cfg.pwm_top} + 17'd1;

    // stage 1: percent times period
    run_prod_nxt   = PROD_W'(run_pct_c) * PROD_W'(top_inc);
    boost_prod_nxt = PROD_W'(boost_pct_c) * PROD_W'(top_inc);

    // stage 2: divide by 100
    run_scaled    = SCALED_W'(run_prod_r) * SCALED_W'(RECIP_100);
    boost_scaled  = SCALED_W'(boost_prod_r) * SCALED_W'(RECIP_100);
    run_quo_nxt   = QUO_W'(run_scaled >> RECIP_SHIFT);
    boost_quo_nxt = QUO_W'(boost_scaled >> RECIP_SHIFT);

    // stage 3: minus one when nonzero, clamp to top
    run_dec       = (run_quo_r != '0) ? run_quo_r - QUO_W'(1) : run_quo_r;
    boost_dec     = (boost_quo_r != '0) ? boost_quo_r - QUO_W'(1) : boost_quo_r;
    run_cmp_nxt   = (run_dec > QUO_W'(cfg.pwm_top)) ? cfg.pwm_top : run_dec[15:0];
    boost_cmp_nxt = (boost_dec > QUO_W'(cfg.pwm_top)) ? cfg.pwm_top : boost_dec[15:0];

    busy_nxt = (busy_r != '0) ? busy_r - 2'd1 : busy_r;
    if (start) begin
      busy_nxt = CALC_CYCLES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= CALC_CYCLES;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_prod_r   <= run_prod_nxt;
    boost_prod_r <= boost_prod_nxt;
    run_quo_r    <= run_quo_nxt;
    boost_quo_r  <= boost_quo_nxt;
    run_cmp_r    <= run_cmp_nxt;
    boost_cmp_r  <= boost_cmp_nxt;
  end

  assign done      = (busy_r == '0);
  assign run_cmp   = run_cmp_r;
  assign boost_cmp = boost_cmp_r;

endmodule

/* hw/rtl/flpc_core.sv */
// debounce, seeding, pump and soft-start state update for one sample
module flpc_core
  import flpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        water,
  input  cfg_t        cfg,
  input  logic        seed_load,
  input  logic [7:0]  seed_value,
  input  logic [15:0] run_cmp,
  input  logic [15:0] boost_cmp,
  output result_t     res
);

  logic [7:0]  water_run_r, water_run_nxt;
  logic [7:0]  empty_run_r, empty_run_nxt;
  logic [1:0]  level_r, level_nxt;
  logic        pump_r, pump_nxt;
  logic [15:0] boost_left_r, boost_left_nxt;
  logic [7:0]  seed_left_r, seed_left_nxt;
  logic [15:0] cmp_r, cmp_nxt;
  logic        seed_tick;

  logic [7:0]  db_wr;
  logic [7:0]  db_er;
  logic [1:0]  db_lvl;

  always_comb begin
    if (water) begin
      db_wr = count_up(water_run_r, cfg.start_count);
      db_er = '0;
    end else begin
      db_er = count_up(empty_run_r, cfg.stop_count);
      db_wr = '0;
    end
    db_lvl = level_r;
    if (db_wr >= cfg.start_count) begin
      db_lvl = LEVEL_FULL;
    end
    if (db_er >= cfg.stop_count) begin
      db_lvl = LEVEL_EMPTY;
    end
  end

  always_comb begin
    water_run_nxt  = water_run_r;
    empty_run_nxt  = empty_run_r;
    level_nxt      = level_r;
    pump_nxt       = pump_r;
    boost_left_nxt = boost_left_r;
    seed_left_nxt  = seed_left_r;
    cmp_nxt        = cmp_r;
    seed_tick      = 1'b0;
    if (boost_left_r != '0) begin
      boost_left_nxt = boost_left_r - 16'd1;
      if (boost_left_r == 16'd1) begin
        cmp_nxt = run_cmp;
      end
    end else if (seed_left_r != '0) begin
      water_run_nxt = db_wr;
      empty_run_nxt = db_er;
      level_nxt     = db_lvl;
      seed_left_nxt = seed_left_r - 8'd1;
      seed_tick     = 1'b1;
    end else begin
      water_run_nxt = db_wr;
      empty_run_nxt = db_er;
      level_nxt     = db_lvl;
      if (db_lvl == LEVEL_EMPTY) begin
        if (pump_r) begin
          pump_nxt = 1'b0;
          cmp_nxt  = '0;
        end
      end else if (db_lvl == LEVEL_FULL) begin
        if (!pump_r) begin
          pump_nxt       = 1'b1;
          boost_left_nxt = cfg.boost_ticks;
          cmp_nxt        = (cfg.boost_ticks != '0) ? boost_cmp : run_cmp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_run_r  <= '0;
      empty_run_r  <= '0;
      level_r      <= LEVEL_UNKNOWN;
      pump_r       <= 1'b0;
      boost_left_r <= '0;
      seed_left_r  <= RST_START_COUNT;
      cmp_r        <= '0;
    end else begin
      if (step) begin
        water_run_r  <= water_run_nxt;
        empty_run_r  <= empty_run_nxt;
        level_r      <= level_nxt;
        pump_r       <= pump_nxt;
        boost_left_r <= boost_left_nxt;
        seed_left_r  <= seed_left_nxt;
        cmp_r        <= cmp_nxt;
      end
      // reload seed count on a start_count write while seeding
      if (seed_load && (seed_left_r != '0)) begin
        seed_left_r <= seed_value;
      end
    end
  end

  always_comb begin
    res.duty        = cmp_nxt;
    res.level_state = level_nxt;
    res.pump_on     = pump_nxt;
    res.boosting    = (boost_left_nxt != '0);
    res.seeding     = seed_tick;
  end

endmodule

/* hw/rtl/flpc_checker.sv */
// port-level checks for the float level pump controller, bound to the top level
module flpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // seeding never runs the pump
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> !out_tdata[18] && (out_tdata[15:0] == 16'd0))
    else $error("pump active during seeding");

  // boost only while the pump runs
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[18])
    else $error("boosting with pump off");

  // stopped pump has zero duty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[18] |-> (out_tdata[15:0] == 16'd0))
    else $error("nonzero duty with pump off");

endmodule

bind float_level_pump_controller flpc_checker u_flpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/tb_float_level_pump_controller.sv */
`timescale 1ns / 100ps
// self-checking testbench for the float level pump controller: directed and random samples
module tb_float_level_pump_controller
  import flpc_pkg::*;
();

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int MAX_IDLE = 17;
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASE_ITEMS = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] switch_wet, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] duty, [17:16] level_state, [18] pump_on,
                           // [19] boosting, [20] seeding, [23:21] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  float_level_pump_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // register mirror
  logic [7:0]  stop_lim;
  logic [7:0]  start_lim;
  logic [6:0]  run_pct;
  logic [6:0]  boost_pct;
  logic [15:0] boost_len;
  logic [15:0] pwm_top;

  // controller state mirror
  logic [7:0]  water_run;
  logic [7:0]  empty_run;
  logic [7:0]  seed_left;
  logic [1:0]  level;
  logic        pump_running;
  logic [15:0] boost_left;
  logic [15:0] cmp_val;

  result_t pump_status_q[$];
  result_t got;
  result_t want;
  int      mismatches = 0;
  bit      send_idle;
  bit      recv_idle;
  int      random_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] percent_compare(logic [6:0] pct, logic [15:0] top);
    logic [31:0] p;
    logic [31:0] v;
    p = (pct > PERCENT_MAX) ? 32'(PERCENT_MAX) : 32'(pct);
    v = (p * (32'(top) + 32'd1)) / 32'(DIVISOR);
    if (v != 0) v = v - 32'd1;
    if (v > 32'(top)) v = 32'(top);
    return v[15:0];
  endfunction

  function automatic logic [7:0] bump_run(logic [7:0] c, logic [7:0] limit);
    logic [7:0] n;
    n = (c != 8'hFF) ? c + 8'd1 : 8'hFF;
    return (n > limit) ? limit : n;
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [6:0] pick_percent();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic reset_model();
    stop_lim     = RST_STOP_COUNT;
    start_lim    = RST_START_COUNT;
    run_pct      = RST_RUN_PCT;
    boost_pct    = RST_BOOST_PCT;
    boost_len    = RST_BOOST_TICKS;
    pwm_top      = RST_PWM_TOP;
    water_run    = '0;
    empty_run    = '0;
    level        = LEVEL_UNKNOWN;
    pump_running = 1'b0;
    boost_left   = '0;
    seed_left    = RST_START_COUNT;
    cmp_val      = '0;
  endtask

  task automatic apply_write(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_STOP_COUNT: stop_lim = data[7:0];
      REG_START_COUNT: begin
        start_lim = data[7:0];
        if (seed_left != 0) seed_left = start_lim;
      end
      REG_RUN_PCT: run_pct = data[6:0];
      REG_BOOST_PCT: boost_pct = data[6:0];
      REG_BOOST_TICKS: boost_len = data;
      REG_PWM_TOP: pwm_top = data;
      default: ;
    endcase
  endtask

  task automatic debounce(bit water);
    if (water) begin
      water_run = bump_run(water_run, start_lim);
      empty_run = '0;
    end else begin
      empty_run = bump_run(empty_run, stop_lim);
      water_run = '0;
    end
    if (water_run >= start_lim) level = LEVEL_FULL;
    if (empty_run >= stop_lim) level = LEVEL_EMPTY;
  endtask

  task automatic predict_status(bit water);
    result_t r;
    bit seed_tick;
    seed_tick = 1'b0;
    if (boost_left != 0) begin
      boost_left = boost_left - 16'd1;
      if (boost_left == 0) cmp_val = percent_compare(run_pct, pwm_top);
    end else if (seed_left != 0) begin
      debounce(water);
      seed_left = seed_left - 8'd1;
      seed_tick = 1'b1;
    end else begin
      debounce(water);
      if (level == LEVEL_EMPTY) begin
        if (pump_running) begin
          pump_running = 1'b0;
          cmp_val = '0;
        end
      end else if (level == LEVEL_FULL && !pump_running) begin
        pump_running = 1'b1;
        boost_left = boost_len;
        cmp_val = (boost_len != 0) ? percent_compare(boost_pct, pwm_top)
                                   : percent_compare(run_pct, pwm_top);
      end
    end
    r.duty        = cmp_val;
    r.level_state = level;
    r.pump_on     = pump_running;
    r.boosting    = (boost_left != 0);
    r.seeding     = seed_tick;
    pump_status_q.push_back(r);
  endtask

  task automatic send_sample(bit water);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, water};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_status(water);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, data);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pump_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic report_mismatch(string what, result_t exp_r, result_t act_r);
    if (mismatches < 10) begin
      $write("%s: expected duty=%0d level=%0d pump=%0b boost=%0b seed=%0b, ",
             what, exp_r.duty, exp_r.level_state, exp_r.pump_on, exp_r.boosting,
             exp_r.seeding);
      $display("got duty=%0d level=%0d pump=%0b boost=%0b seed=%0b",
               act_r.duty, act_r.level_state, act_r.pump_on, act_r.boosting,
               act_r.seeding);
    end
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[20:0]);
      if (pump_status_q.size() == 0) begin
        report_mismatch("unexpected item", '0, got);
      end else begin
        want = pump_status_q.pop_front();
        if (got.duty != want.duty || got.level_state != want.level_state ||
            got.pump_on != want.pump_on || got.boosting != want.boosting ||
            got.seeding != want.seeding)
          report_mismatch("mismatch", want, got);
      end
    end
  end

  // result receiver with random stalls
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // seed ticks, seed reload and seed cut short by a zero start count
  task automatic test_seed_reload();
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b1);
    drain();
    write_reg(REG_START_COUNT, 16'd4);
    end_writes();
    send_sample(1'b1);
    send_sample(1'b0);
    drain();
    write_reg(REG_START_COUNT, 16'd0);
    end_writes();
  endtask

  // zero limits, empty priority, start without boost, clamped duty at the largest pwm top
  task automatic test_zero_limits();
    drain();
    write_reg(REG_STOP_COUNT, 16'd0);
    end_writes();
    send_sample(1'b1);
    send_sample(1'b0);
    drain();
    write_reg(REG_BOOST_TICKS, 16'd0);
    write_reg(REG_RUN_PCT, 16'd127);
    write_reg(REG_PWM_TOP, 16'hFFFF);
    write_reg(REG_STOP_COUNT, 16'd3);
    end_writes();
    send_sample(1'b1);
    drain();
    write_reg(REG_BOOST_TICKS, 16'hFFFF);
    write_reg(REG_PWM_TOP, 16'd1);
    end_writes();
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b0);
  endtask

  // boost start, writes during boost, end of boost, unused register indexes
  task automatic test_boost_hold();
    drain();
    write_reg(REG_BOOST_TICKS, 16'd2);
    write_reg(REG_BOOST_PCT, 16'd0);
    write_reg(REG_START_COUNT, 16'd2);
    end_writes();
    send_sample(1'b1);
    send_sample(1'b1);
    drain();
    write_reg(REG_RUN_PCT, 16'd100);
    write_reg(REG_PWM_TOP, 16'd3);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    end_writes();
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b0);
  endtask

  // random settings per phase, debounce runs around the limits plus single-sample noise
  task automatic test_random_levels();
    int n;
    int len;
    int lim;
    bit water;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      write_reg(REG_STOP_COUNT, {8'b0, pick_limit()});
      write_reg(REG_START_COUNT, {8'b0, pick_limit()});
      write_reg(REG_RUN_PCT, {9'b0, pick_percent()});
      write_reg(REG_BOOST_PCT, {9'b0, pick_percent()});
      case ($urandom_range(0, 3))
        0: write_reg(REG_BOOST_TICKS, 16'd0);
        default: write_reg(REG_BOOST_TICKS, 16'($urandom_range(1, 25)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_PWM_TOP, 16'd1);
        1: write_reg(REG_PWM_TOP, 16'hFFFF);
        default: write_reg(REG_PWM_TOP, 16'($urandom_range(1, 65535)));
      endcase
      end_writes();
      case ($urandom_range(0, 3))
        0: begin send_idle = 1'b0; recv_idle = 1'b0; end
        1: begin send_idle = 1'b1; recv_idle = 1'b1; end
        2: begin send_idle = 1'b1; recv_idle = 1'b0; end
        default: begin send_idle = 1'b0; recv_idle = 1'b1; end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        water = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
          send_sample(water);
          n++;
        end else begin
          lim = water ? int'(start_lim) : int'(stop_lim);
          len = $urandom_range(1, lim + 2);
          repeat (len) send_sample(water);
          n += len;
        end
      end
      random_sent += n;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    reset_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_seed_reload();
    test_zero_limits();
    test_boost_hold();
    test_random_levels();
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pump_status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
